[sv/prb_pkg.sv]
// Shared types and constants for the packet reorder buffer.
// No dependencies; packet_reorder_buffer imports this package.
package prb_pkg;

    localparam int FIELD_W   = 16;
    localparam int BATCH_W   = 8;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [1:0] {
        ST_RELEASED = 2'd0,
        ST_LATE_DUP = 2'd1,
        ST_BEYOND   = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BATCH_LENGTH = 2'd0,
        REG_START_SEQ    = 2'd1
    } cfg_reg_t;

    typedef struct packed {
        logic [FIELD_W-1:0] seq_number;
        logic [FIELD_W-1:0] payload_tag;
        logic               final_req;
    } in_beat_t;

    typedef struct packed {
        logic [FIELD_W-1:0] out_seq;
        logic [FIELD_W-1:0] out_tag;
        status_t            status;
        logic               last_of_run;
    } out_beat_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [FIELD_W-1:0]   value;
    } cfg_beat_t;

endpackage

[sv/prb_stream_if.sv]
// Valid/ready channel carrying one beat of payload type T.
// Used with the beat structs of prb_pkg.
interface prb_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[sv/packet_reorder_buffer.sv]
// Packet reorder buffer: one slot memory of WINDOW entries holds {valid, tag}, used as a
// ring that starts at the next expected sequence number. Each packet is accepted and its
// slot read, then checked and written back. A dropped packet that ends no batch then goes
// through a flush state to hand on its report beat. At a release point the block drains
// the run in order, one released packet at a time (read its slot, then hand on the beat
// held before, hold this one and clear its slot), then reads the empty slot that ends the
// run and hands on the last beat. Every cycle the output register stays full while a beat
// is held stalls the drain. After reset and after each write of start_seq a clearing pass
// sweeps all WINDOW slots of the memory; packets are held off during it. Drop reports
// (late, duplicate, beyond the window) come before any released packets of the same input;
// last_of_run marks the final result of each input. Depends on prb_pkg and prb_stream_if.
module packet_reorder_buffer #(
    parameter int WINDOW   = 32,
    parameter int SEQ_BITS = 16,
    parameter int TAG_BITS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    prb_stream_if.sink   pkt,
    prb_stream_if.source res,
    prb_stream_if.sink   cfg
);
    import prb_pkg::*;

    localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    typedef enum logic [5:0] {
        S_CLEAR    = 6'b000001,
        S_IDLE     = 6'b000010,
        S_LOOK     = 6'b000100,
        S_SCAN_RD  = 6'b001000,
        S_SCAN_CHK = 6'b010000,
        S_FLUSH    = 6'b100000
    } state_t;

    // slot memory
    logic [TAG_BITS:0] slot_mem [WINDOW];
    logic [TAG_BITS:0] rd_data_reg;
    logic              wr_en, rd_en;
    logic [IDX_W-1:0]  wr_addr, rd_addr;
    logic [TAG_BITS:0] wr_data;

    // control state
    state_t                state_reg, state_next;
    logic [IDX_W-1:0]      clr_reg, clr_next;
    logic [IDX_W-1:0]      base_reg, base_next;
    logic [SEQ_BITS-1:0]   expected_reg, expected_next;
    logic [BATCH_W-1:0]    cnt_reg, cnt_next;
    logic [BATCH_W-1:0]    batch_len_reg, batch_len_next;
    logic                  pend_valid_reg, pend_valid_next;
    logic                  out_valid_reg, out_valid_next;

    // payload state
    logic [SEQ_BITS-1:0]   seq_reg, seq_next;
    logic [TAG_BITS-1:0]   tag_reg, tag_next;
    logic [IDX_W-1:0]      slot_reg, slot_next;
    logic                  late_reg, late_next;
    logic                  beyond_reg, beyond_next;
    logic                  rel_reg, rel_next;
    logic [SEQ_BITS-1:0]   pend_seq_reg, pend_seq_next;
    logic [TAG_BITS-1:0]   pend_tag_reg, pend_tag_next;
    status_t               pend_status_reg, pend_status_next;
    out_beat_t             out_data_reg, out_data_next;

    logic                  pkt_acc, cfg_acc, out_free, emit, emit_last;
    logic [SEQ_BITS-1:0]   in_seq, in_dist;
    logic [31:0]           dist32;
    logic [IDX_W:0]        slot_sum;
    logic [IDX_W-1:0]      in_slot, base_inc;
    logic [BATCH_W-1:0]    cnt_inc;

    assign pkt.ready = (state_reg == S_IDLE) && !cfg.valid;
    assign cfg.ready = (state_reg == S_IDLE) || (state_reg == S_CLEAR);
    assign pkt_acc   = pkt.valid && pkt.ready;
    assign cfg_acc   = cfg.valid && cfg.ready;
    assign out_free  = !out_valid_reg || res.ready;

    assign res.valid = out_valid_reg;
    assign res.data  = out_data_reg;

    // slot of the incoming packet: base plus distance, wrapped once
    assign in_seq   = SEQ_BITS'(pkt.data.seq_number);
    assign in_dist  = in_seq - expected_reg;
    assign dist32   = 32'(in_dist);
    assign slot_sum = {1'b0, base_reg} + {1'b0, dist32[IDX_W-1:0]};
    assign in_slot  = (slot_sum >= (IDX_W+1)'(WINDOW)) ?
                      IDX_W'(slot_sum - (IDX_W+1)'(WINDOW)) : IDX_W'(slot_sum);
    assign base_inc = (base_reg == IDX_W'(WINDOW - 1)) ? '0 : base_reg + 1'b1;
    assign cnt_inc  = cnt_reg + 1'b1;

    always_comb
    begin
        state_next       = state_reg;
        clr_next         = clr_reg;
        base_next        = base_reg;
        expected_next    = expected_reg;
        cnt_next         = cnt_reg;
        batch_len_next   = batch_len_reg;
        pend_valid_next  = pend_valid_reg;
        seq_next         = seq_reg;
        tag_next         = tag_reg;
        slot_next        = slot_reg;
        late_next        = late_reg;
        beyond_next      = beyond_reg;
        rel_next         = rel_reg;
        pend_seq_next    = pend_seq_reg;
        pend_tag_next    = pend_tag_reg;
        pend_status_next = pend_status_reg;
        wr_en            = 1'b0;
        wr_addr          = slot_reg;
        wr_data          = '0;
        rd_en            = 1'b0;
        rd_addr          = slot_reg;
        emit             = 1'b0;
        emit_last        = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_reg;
                if (clr_reg == IDX_W'(WINDOW - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (pkt_acc)
                begin
                    seq_next    = in_seq;
                    tag_next    = TAG_BITS'(pkt.data.payload_tag);
                    slot_next   = in_slot;
                    late_next   = in_dist[SEQ_BITS-1];
                    beyond_next = dist32 >= 32'(WINDOW);
                    rd_en       = 1'b1;
                    rd_addr     = in_slot;
                    if (pkt.data.final_req || (cnt_inc >= batch_len_reg))
                    begin
                        rel_next = 1'b1;
                        cnt_next = '0;
                    end
                    else
                    begin
                        rel_next = 1'b0;
                        cnt_next = cnt_inc;
                    end
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                pend_seq_next = seq_reg;
                pend_tag_next = tag_reg;
                priority if (late_reg)
                begin
                    pend_valid_next  = 1'b1;
                    pend_status_next = ST_LATE_DUP;
                end
                else if (beyond_reg)
                begin
                    pend_valid_next  = 1'b1;
                    pend_status_next = ST_BEYOND;
                end
                else if (rd_data_reg[TAG_BITS])
                begin
                    pend_valid_next  = 1'b1;
                    pend_status_next = ST_LATE_DUP;
                end
                else
                begin
                    wr_en   = 1'b1;
                    wr_data = {1'b1, tag_reg};
                end
                priority if (rel_reg)
                begin
                    state_next = S_SCAN_RD;
                end
                else if (late_reg || beyond_reg || rd_data_reg[TAG_BITS])
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_SCAN_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = base_reg;
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                if (!rd_data_reg[TAG_BITS])
                begin
                    state_next = S_FLUSH;
                end
                else if (!pend_valid_reg || out_free)
                begin
                    // hand the held beat on, then hold this slot until the next one shows
                    emit             = pend_valid_reg;
                    pend_valid_next  = 1'b1;
                    pend_seq_next    = expected_reg;
                    pend_tag_next    = rd_data_reg[TAG_BITS-1:0];
                    pend_status_next = ST_RELEASED;
                    wr_en            = 1'b1;
                    wr_addr          = base_reg;
                    base_next        = base_inc;
                    expected_next    = expected_reg + 1'b1;
                    state_next       = S_SCAN_RD;
                end
            end
            S_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    emit            = 1'b1;
                    emit_last       = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
                clr_next   = '0;
            end
        endcase

        if (cfg_acc)
        begin
            if (cfg.data.index == REG_BATCH_LENGTH)
            begin
                batch_len_next = cfg.data.value[BATCH_W-1:0];
            end
            else if (cfg.data.index == REG_START_SEQ)
            begin
                expected_next = SEQ_BITS'(cfg.data.value);
                base_next     = '0;
                cnt_next      = '0;
                clr_next      = '0;
                state_next    = S_CLEAR;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (emit)
        begin
            out_valid_next            = 1'b1;
            out_data_next.out_seq     = FIELD_W'(pend_seq_reg);
            out_data_next.out_tag     = FIELD_W'(pend_tag_reg);
            out_data_next.status      = pend_status_reg;
            out_data_next.last_of_run = emit_last;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= slot_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_reg        <= '0;
            base_reg       <= '0;
            expected_reg   <= '0;
            cnt_reg        <= '0;
            batch_len_reg  <= BATCH_W'(1);
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            base_reg       <= base_next;
            expected_reg   <= expected_next;
            cnt_reg        <= cnt_next;
            batch_len_reg  <= batch_len_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        seq_reg         <= seq_next;
        tag_reg         <= tag_next;
        slot_reg        <= slot_next;
        late_reg        <= late_next;
        beyond_reg      <= beyond_next;
        rel_reg         <= rel_next;
        pend_seq_reg    <= pend_seq_next;
        pend_tag_reg    <= pend_tag_next;
        pend_status_reg <= pend_status_next;
        out_data_reg    <= out_data_next;
    end

    a_no_pend_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        pkt.ready |-> !pend_valid_reg)
        else $error("packet accepted while a result is still held");

    a_single_port_use: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && rd_en))
        else $error("slot memory read and written in the same cycle");

    a_quiet_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !emit && !pend_valid_reg)
        else $error("result produced during clearing pass");

    a_release_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN_CHK && rd_data_reg[TAG_BITS] && (!pend_valid_reg || out_free))
        |=> expected_reg == $past(expected_reg) + 1'b1)
        else $error("expected sequence did not advance on release");

endmodule
